FILE: hw/rtl/rr_sched_pkg.sv
// shared types and codes for the round robin thread scheduler
`timescale 1ns / 1ps

package rr_sched_pkg;

  // request operation codes as carried in the func field
  typedef enum logic [2:0] {
    FN_CREATE  = 3'd0,
    FN_TICK    = 3'd1,
    FN_SCHED   = 3'd2,
    FN_BLOCK   = 3'd3,
    FN_UNBLOCK = 3'd4,
    FN_DELAY   = 3'd5
  } func_t;

  // thread status held in each cell
  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_SLEEPING = 2'd2
  } thread_st_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CREATE,
    OP_TICK,
    OP_BLOCK,
    OP_DELAY,
    OP_UNBLOCK,
    OP_SCHED
  } cell_op_t;

  // controller sequence states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } sched_state_t;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  sem;
    logic [31:0] wake;
    logic [31:0] clock;
    logic        last_move;
  } cell_cmd_t;

  typedef struct packed {
    logic tok;
    logic hit;
    logic fwd;
    logic wrap;
  } cell_rsp_t;

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 48;

endpackage

FILE: hw/rtl/round_robin_thread_scheduler_top.sv
// round robin thread scheduler: request sequencer and the chain of thread slots
//
//  channel | direction | handshake         | payload
//  in_     | request   | tvalid/tready     | func, sem_id, delay_ms
//  out_    | result    | tvalid/tready     | current_thread, current_valid, ok,
//          |           |                   | threads_used, time_now
//
// create, tick, block, delay and unused codes go from idle straight to done;
// schedule and unblock first scan, the token visiting at most as many slots as
// there are created threads, as the token walks the slot chain one cell a cycle.
// rst_n is synchronous; slot contents are not reset, only the control state.
// a new request is taken while an earlier result still waits on out_tready;
// the result of that request is held back until the output register frees.
`timescale 1ns / 1ps

module round_robin_thread_scheduler_top #(
  parameter int unsigned NUM_THREADS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] func, [10:3] sem_id, [42:11] delay_ms, [47:43] zero
  input  logic [rr_sched_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] current_thread, [3] current_valid, [4] ok, [8:5] threads_used,
  // [40:9] time_now, [47:41] zero
  output logic [rr_sched_pkg::OUT_W-1:0]  out_tdata
);

  localparam int unsigned CW = $clog2(NUM_THREADS + 1);
  localparam int unsigned IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  rr_sched_pkg::sched_state_t state_r, state_nxt;
  rr_sched_pkg::cell_op_t     op_r, op_nxt;
  rr_sched_pkg::cell_cmd_t    cmd;
  rr_sched_pkg::cell_rsp_t    rsp [NUM_THREADS];

  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  moves_r, moves_nxt;
  logic [IW-1:0]  cur_r, cur_nxt;
  logic [31:0]    clock_r, clock_nxt;
  logic           ok_r, ok_nxt;
  logic           out_valid_r;
  logic [rr_sched_pkg::OUT_W-1:0] out_data_r;
  logic           load_out;

  logic           in_fire;
  logic [2:0]     func;
  logic [7:0]     sem_id;
  logic [31:0]    delay_ms;

  logic [NUM_THREADS-1:0] hit_v, fwd_v, wrap_v, tok_v, inj_v, sel_v;
  logic [IW-1:0]  hit_idx;
  logic [CW-1:0]  cur_inc;
  logic [IW-1:0]  start_idx;
  logic           inj_sched, inj_unblk;
  logic [2:0]     cur3;

  assign func     = in_tdata[2:0];
  assign sem_id   = in_tdata[10:3];
  assign delay_ms = in_tdata[42:11];
  assign in_tready = (state_r == rr_sched_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // round robin successor of the current thread
  assign cur_inc   = CW'(cur_r) + CW'(1);
  assign start_idx = (cur_inc >= count_r) ? IW'(0) : IW'(cur_inc);

  // index of the slot that stops the token
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_THREADS; i++) begin
      if (hit_v[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  // sequencer: next state, slot command and token injection
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    count_nxt     = count_r;
    moves_nxt     = moves_r;
    cur_nxt       = cur_r;
    clock_nxt     = clock_r;
    ok_nxt        = ok_r;
    load_out      = 1'b0;
    inj_sched     = 1'b0;
    inj_unblk     = 1'b0;
    cmd.op        = rr_sched_pkg::OP_NONE;
    cmd.sem       = sem_id;
    cmd.wake      = clock_r + delay_ms;
    cmd.clock     = clock_r + 32'd1;
    cmd.last_move = (moves_r == CW'(1));
    case (state_r)
      rr_sched_pkg::S_IDLE: begin
        if (in_fire) begin
          ok_nxt    = 1'b0;
          state_nxt = rr_sched_pkg::S_DONE;
          case (func)
            rr_sched_pkg::FN_CREATE: begin
              if (count_r < CW'(NUM_THREADS)) begin
                cmd.op    = rr_sched_pkg::OP_CREATE;
                count_nxt = count_r + CW'(1);
                ok_nxt    = 1'b1;
                if (count_r == '0) cur_nxt = '0;
              end
            end
            rr_sched_pkg::FN_TICK: begin
              cmd.op    = rr_sched_pkg::OP_TICK;
              clock_nxt = clock_r + 32'd1;
            end
            rr_sched_pkg::FN_SCHED: begin
              if (count_r != '0) begin
                inj_sched = 1'b1;
                moves_nxt = count_r;
                op_nxt    = rr_sched_pkg::OP_SCHED;
                state_nxt = rr_sched_pkg::S_SCAN;
              end
            end
            rr_sched_pkg::FN_BLOCK: begin
              if (count_r != '0) cmd.op = rr_sched_pkg::OP_BLOCK;
            end
            rr_sched_pkg::FN_UNBLOCK: begin
              if (count_r != '0) begin
                inj_unblk = 1'b1;
                op_nxt    = rr_sched_pkg::OP_UNBLOCK;
                state_nxt = rr_sched_pkg::S_SCAN;
              end
            end
            rr_sched_pkg::FN_DELAY: begin
              if (count_r != '0) cmd.op = rr_sched_pkg::OP_DELAY;
            end
            default: begin
            end
          endcase
        end
      end
      rr_sched_pkg::S_SCAN: begin
        cmd.op    = op_r;
        cmd.sem   = '0;
        moves_nxt = moves_r - CW'(1);
        if (|hit_v) begin
          if (op_r == rr_sched_pkg::OP_SCHED) cur_nxt = hit_idx;
          else ok_nxt = 1'b1;
        end
        if (!(|fwd_v) && !(|wrap_v)) state_nxt = rr_sched_pkg::S_DONE;
      end
      rr_sched_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = rr_sched_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rr_sched_pkg::S_IDLE;
      end
    endcase
  end

  // semaphore for the unblock scan is held from the request
  logic [7:0] sem_r;
  always_ff @(posedge clk) begin
    if (in_fire) sem_r <= sem_id;
  end

  rr_sched_pkg::cell_cmd_t cell_cmd;
  always_comb begin
    cell_cmd = cmd;
    if (state_r == rr_sched_pkg::S_SCAN) cell_cmd.sem = sem_r;
  end

  // the slot chain: token moves one cell a cycle, wrapping at the last created thread on a schedule
  genvar g;
  generate
    for (g = 0; g < NUM_THREADS; g++) begin : g_cell
      logic tok_in;
      assign sel_v[g] = (cmd.op == rr_sched_pkg::OP_CREATE) ? (count_r == CW'(g))
                                                             : (cur_r == IW'(g));
      assign inj_v[g] = (inj_sched && start_idx == IW'(g)) || (inj_unblk && g == 0);
      if (g == 0) begin : g_head
        assign tok_in = inj_v[g] || (|wrap_v);
      end else begin : g_body
        assign tok_in = inj_v[g] || fwd_v[g-1];
      end

      rr_sched_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cell_cmd),
        .sel     (sel_v[g]),
        .created (CW'(g) < count_r),
        .is_last (CW'(g + 1) == count_r),
        .tok_in  (tok_in),
        .rsp     (rsp[g])
      );

      assign hit_v[g]  = rsp[g].hit;
      assign fwd_v[g]  = rsp[g].fwd;
      assign wrap_v[g] = rsp[g].wrap;
      assign tok_v[g]  = rsp[g].tok;
    end
  endgenerate

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rr_sched_pkg::S_IDLE;
      op_r    <= rr_sched_pkg::OP_NONE;
      count_r <= '0;
      moves_r <= '0;
      cur_r   <= '0;
      clock_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      count_r <= count_nxt;
      moves_r <= moves_nxt;
      cur_r   <= cur_nxt;
      clock_r <= clock_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // result register
  assign cur3 = 3'(cur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {7'd0, clock_r, 4'(count_r), ok_r, (count_r != '0), cur3};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // at most one slot holds the scan token
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_v))
    else $error("more than one scan token in the slot chain");

  // no token left in the chain once the sequencer is idle
  a_idle_no_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rr_sched_pkg::S_IDLE) |-> (tok_v == '0))
    else $error("scan token alive while idle");

  // current thread always names a created thread
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (CW'(cur_r) < count_r))
    else $error("current thread beyond created threads");

  // thread count never passes the table size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NUM_THREADS))
    else $error("thread count overflow");

endmodule

FILE: hw/rtl/rr_sched_cell.sv
// one thread slot of the scheduler chain, with the scan token it passes on
`timescale 1ns / 1ps

module rr_sched_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rr_sched_pkg::cell_cmd_t cmd,
  input  logic                    sel,      // this slot is the target of a write
  input  logic                    created,  // slot holds a created thread
  input  logic                    is_last,  // slot is the last created thread
  input  logic                    tok_in,   // token from the neighbour or injection
  output rr_sched_pkg::cell_rsp_t rsp
);

  rr_sched_pkg::thread_st_t st_r, st_nxt;
  logic [7:0]               sem_r, sem_nxt;
  logic [31:0]              wake_r, wake_nxt;
  logic                     tok_r;
  logic [31:0]              diff;
  logic                     parked;
  logic                     hit;
  logic                     pass;

  assign diff   = cmd.clock - wake_r;
  assign parked = (st_r == rr_sched_pkg::ST_BLOCKED) || (st_r == rr_sched_pkg::ST_SLEEPING);

  // token evaluation and slot update
  always_comb begin
    st_nxt   = st_r;
    sem_nxt  = sem_r;
    wake_nxt = wake_r;
    hit      = 1'b0;
    case (cmd.op)
      rr_sched_pkg::OP_CREATE: begin
        if (sel) begin
          st_nxt  = rr_sched_pkg::ST_READY;
          sem_nxt = 8'd0;
        end
      end
      rr_sched_pkg::OP_TICK: begin
        if (created && st_r == rr_sched_pkg::ST_SLEEPING && !diff[31]) begin
          st_nxt = rr_sched_pkg::ST_READY;
        end
      end
      rr_sched_pkg::OP_BLOCK: begin
        if (sel) begin
          st_nxt  = rr_sched_pkg::ST_BLOCKED;
          sem_nxt = cmd.sem;
        end
      end
      rr_sched_pkg::OP_DELAY: begin
        if (sel) begin
          st_nxt   = rr_sched_pkg::ST_SLEEPING;
          wake_nxt = cmd.wake;
        end
      end
      rr_sched_pkg::OP_UNBLOCK: begin
        hit = tok_r && created && st_r == rr_sched_pkg::ST_BLOCKED && sem_r == cmd.sem;
        if (hit) begin
          st_nxt  = rr_sched_pkg::ST_READY;
          sem_nxt = 8'd0;
        end
      end
      rr_sched_pkg::OP_SCHED: begin
        hit = tok_r && (!parked || cmd.last_move);
      end
      default: begin
      end
    endcase
  end

  assign pass     = tok_r && !hit &&
                    (cmd.op == rr_sched_pkg::OP_UNBLOCK || cmd.op == rr_sched_pkg::OP_SCHED);
  assign rsp.tok  = tok_r;
  assign rsp.hit  = hit;
  assign rsp.fwd  = pass && !is_last;
  assign rsp.wrap = pass && is_last && (cmd.op == rr_sched_pkg::OP_SCHED);

  // slot contents, written when a thread is created or parked, and when a tick or an unblock readies it
  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    sem_r  <= sem_nxt;
    wake_r <= wake_nxt;
  end

  // scan token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

endmodule

FILE: test/round_robin_thread_scheduler_top_test.sv
// self-checking stream test of the round robin thread scheduler against its own thread table
`timescale 1ns / 1ps

module round_robin_thread_scheduler_top_test;

  localparam int unsigned SLOTS        = 8;
  localparam logic [2:0]  FN_SPARE6    = 3'd6;
  localparam logic [2:0]  FN_SPARE7    = 3'd7;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 32;

  // one result as seen on out_tdata
  typedef struct packed {
    logic [2:0]  cur;
    logic        valid;
    logic        ok;
    logic [3:0]  used;
    logic [31:0] now;
  } sched_view_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [rr_sched_pkg::IN_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [rr_sched_pkg::OUT_W-1:0] out_tdata;

  // own copy of the thread table
  rr_sched_pkg::thread_st_t slot_status [SLOTS];
  logic [7:0]           slot_sem    [SLOTS];
  logic [31:0]          slot_wake   [SLOTS];
  int unsigned          cur_idx   = 0;
  int unsigned          n_threads = 0;
  logic [31:0]          ms_clock  = '0;

  sched_view_t          results_due [$];
  int unsigned          errors       = 0;
  bit                   quiet        = 1'b0;
  bit                   hold_pending = 1'b0;
  int unsigned          stall_left   = 0;
  int unsigned          hold_left    = 0;
  int unsigned          idle_cycles  = 0;

  round_robin_thread_scheduler_top #(
    .NUM_THREADS(SLOTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_parked(input int unsigned idx);
    return slot_status[idx] == rr_sched_pkg::ST_BLOCKED ||
           slot_status[idx] == rr_sched_pkg::ST_SLEEPING;
  endfunction

  // apply one request to the thread table and queue the result it gives
  function automatic void step_thread_table(input logic [2:0] fn, input logic [7:0] sem,
                                            input logic [31:0] delay);
    sched_view_t r;
    int unsigned moves;
    logic        ok;
    logic [31:0] lag;
    ok = 1'b0;
    case (fn)
      rr_sched_pkg::FN_CREATE: begin
        if (n_threads < SLOTS) begin
          slot_status[n_threads] = rr_sched_pkg::ST_READY;
          slot_sem[n_threads]    = 8'h00;
          if (n_threads == 0) cur_idx = 0;
          n_threads++;
          ok = 1'b1;
        end
      end
      rr_sched_pkg::FN_TICK: begin
        ms_clock = ms_clock + 32'd1;
        for (int i = 0; i < n_threads; i++) begin
          lag = ms_clock - slot_wake[i];
          if (slot_status[i] == rr_sched_pkg::ST_SLEEPING && !lag[31])
            slot_status[i] = rr_sched_pkg::ST_READY;
        end
      end
      rr_sched_pkg::FN_SCHED: begin
        if (n_threads != 0) begin
          moves = n_threads;
          do begin
            cur_idx = cur_idx + 1;
            if (cur_idx >= n_threads) cur_idx = 0;
            moves--;
          end while (moves != 0 && is_parked(cur_idx));
        end
      end
      rr_sched_pkg::FN_BLOCK: begin
        if (n_threads != 0) begin
          slot_status[cur_idx] = rr_sched_pkg::ST_BLOCKED;
          slot_sem[cur_idx]    = sem;
        end
      end
      rr_sched_pkg::FN_UNBLOCK: begin
        for (int i = 0; i < n_threads; i++) begin
          if (!ok && slot_status[i] == rr_sched_pkg::ST_BLOCKED && slot_sem[i] == sem) begin
            slot_status[i] = rr_sched_pkg::ST_READY;
            slot_sem[i]    = 8'h00;
            ok = 1'b1;
          end
        end
      end
      rr_sched_pkg::FN_DELAY: begin
        if (n_threads != 0) begin
          slot_wake[cur_idx]   = ms_clock + delay;
          slot_status[cur_idx] = rr_sched_pkg::ST_SLEEPING;
        end
      end
      default: ;
    endcase
    r.cur   = cur_idx[2:0];
    r.valid = n_threads != 0;
    r.ok    = ok;
    r.used  = n_threads[3:0];
    r.now   = ms_clock;
    results_due.push_back(r);
  endfunction

  // offer one request, with a random gap before it unless quiet
  task automatic send_request(input logic [2:0] fn, input logic [7:0] sem,
                              input logic [31:0] delay);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, delay, sem, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_thread_table(fn, sem, delay);
  endtask

  // semaphore ids that blocked threads wait on; together they toggle every bit
  function automatic logic [7:0] pool_sem(input int unsigned idx);
    case (idx)
      0:       return 8'h00;
      1:       return 8'h5A;
      2:       return 8'hA5;
      default: return 8'hFF;
    endcase
  endfunction

  // nothing to act on before the first create
  task automatic test_empty_table();
    send_request(rr_sched_pkg::FN_SCHED,   8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_BLOCK,   8'hFF, 32'd0);
    send_request(rr_sched_pkg::FN_DELAY,   8'h01, 32'd5);
    send_request(rr_sched_pkg::FN_UNBLOCK, 8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_TICK,    8'h00, 32'd0);
    send_request(FN_SPARE6,                8'hFF, 32'hFFFF_FFFF);
    send_request(FN_SPARE7,                8'h00, 32'd0);
  endtask

  // first threads and a full turn of the round robin with wrap
  task automatic test_create_rotation();
    repeat (3) send_request(rr_sched_pkg::FN_CREATE, 8'h00, 32'd0);
    repeat (3) send_request(rr_sched_pkg::FN_SCHED, 8'h00, 32'd0);
  endtask

  // block on semaphore zero and on the top id, miss once, then wake both
  task automatic test_block_wake();
    send_request(rr_sched_pkg::FN_BLOCK,   8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_SCHED,   8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_BLOCK,   8'hFF, 32'd0);
    send_request(rr_sched_pkg::FN_SCHED,   8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_UNBLOCK, 8'h5A, 32'd0);
    send_request(rr_sched_pkg::FN_UNBLOCK, 8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_UNBLOCK, 8'hFF, 32'd0);
  endtask

  // zero delay, a delay that wraps into the past and a short sleep
  task automatic test_sleep_wake();
    send_request(rr_sched_pkg::FN_DELAY, 8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_TICK,  8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_DELAY, 8'h00, 32'hFFFF_FFFF);
    send_request(rr_sched_pkg::FN_TICK,  8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_DELAY, 8'h00, 32'd2);
    send_request(rr_sched_pkg::FN_SCHED, 8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_TICK,  8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_TICK,  8'h00, 32'd0);
  endtask

  // weighted random requests; blocks use the pool so that unblocks find them
  task automatic test_random_mix(input int unsigned count);
    int unsigned pick;
    logic [2:0]  fn;
    logic [7:0]  sem;
    logic [31:0] delay;
    logic [31:0] raw;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       fn = rr_sched_pkg::FN_CREATE;
      else if (pick < 30) fn = rr_sched_pkg::FN_TICK;
      else if (pick < 55) fn = rr_sched_pkg::FN_SCHED;
      else if (pick < 67) fn = rr_sched_pkg::FN_BLOCK;
      else if (pick < 82) fn = rr_sched_pkg::FN_UNBLOCK;
      else if (pick < 97) fn = rr_sched_pkg::FN_DELAY;
      else if (pick < 99) fn = FN_SPARE6;
      else                fn = FN_SPARE7;
      if (fn == rr_sched_pkg::FN_BLOCK ||
          (fn == rr_sched_pkg::FN_UNBLOCK && $urandom_range(0, 6) != 0))
        sem = pool_sem($urandom_range(0, 3));
      else
        sem = 8'($urandom_range(0, 255));
      raw = $urandom();
      // short sleeps mostly; a top bit set mostly puts the wake time in the past
      if (fn != rr_sched_pkg::FN_DELAY)  delay = raw;
      else if ($urandom_range(0, 9) < 7) delay = $urandom_range(0, 12);
      else                               delay = raw | 32'h8000_0000;
      send_request(fn, sem, delay);
    end
  endtask

  // receiver holds off for a long stretch so the block stalls its input
  task automatic test_backpressure();
    hold_pending = 1'b1;
    test_random_mix(40);
  endtask

  // sleeps half the clock range away and more, which never end in this run
  task automatic test_long_sleep();
    send_request(rr_sched_pkg::FN_DELAY,   8'h00, 32'h7FFF_FFFF);
    send_request(rr_sched_pkg::FN_TICK,    8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_SCHED,   8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_DELAY,   8'h00, 32'h8000_0000);
    send_request(rr_sched_pkg::FN_TICK,    8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_SCHED,   8'h00, 32'd0);
    send_request(rr_sched_pkg::FN_UNBLOCK, 8'hA5, 32'd0);
  endtask

  // result side ready, with random stalls and one long hold
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_pending) begin
      out_tready   <= 1'b0;
      hold_left    <= LONG_HOLD - 1;
      hold_pending <= 1'b0;
    end else if (!quiet && stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // check each accepted result against the oldest one due
  always @(posedge clk) begin
    sched_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing due, expected none actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = results_due.pop_front();
        compare_field("current_thread", 32'(want.cur),   32'(out_tdata[2:0]));
        compare_field("current_valid",  32'(want.valid), 32'(out_tdata[3]));
        compare_field("ok",             32'(want.ok),    32'(out_tdata[4]));
        compare_field("threads_used",   32'(want.used),  32'(out_tdata[8:5]));
        compare_field("time_now",       want.now,        out_tdata[40:9]);
      end
    end
  end

  // watchdog on cycles in which neither side moves a request or result
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("round_robin_thread_scheduler_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    foreach (slot_status[i]) begin
      slot_status[i] = rr_sched_pkg::ST_READY;
      slot_sem[i]    = 8'h00;
      slot_wake[i]   = 32'd0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_create_rotation();
    test_block_wake();
    test_sleep_wake();
    test_random_mix(1600);
    test_backpressure();
    quiet = 1'b1;
    test_random_mix(180);
    test_long_sleep();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("round_robin_thread_scheduler_top verification clean");
    end else begin
      $display("round_robin_thread_scheduler_top verification failed");
    end
    $finish;
  end

endmodule
